[design/mpv_pkg.sv]
// Shared constants, codes and types of the matrix product verifier.
// Used by the verifier top, mpv_cell and the test files; depends on nothing.
package mpv_pkg;

  // Array geometry and arithmetic widths
  localparam int MAX_SIZE  = 16;
  localparam int ELEM_W    = 16;
  localparam int ACC_W     = 48;
  localparam int IDX_W     = $clog2(MAX_SIZE);
  localparam int SIZE_W    = $clog2(MAX_SIZE + 1);
  localparam int BX_W      = ELEM_W + IDX_W + 1;
  localparam int PROD_W    = ELEM_W + BX_W;
  localparam int RAM_AW    = IDX_W + 2;
  localparam int RAM_DEPTH = 3 << IDX_W;
  localparam int STEP_W    = $clog2(2 * MAX_SIZE + 1);
  // drain length that lets a cell's last read reach its accumulator
  localparam int PIPE_LAT  = 2;

  // Fixed field widths of the ports
  localparam int CMD_W      = 2;
  localparam int SEL_W      = 2;
  localparam int POS_W      = 4;
  localparam int VALUE_W    = 16;
  localparam int RAND_W     = 16;
  localparam int MSIZE_W    = 5;
  localparam int RCOUNT_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ROUND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Matrix selects, also the upper bits of a cell RAM address
  localparam logic [SEL_W-1:0] SEL_A = 2'd0;
  localparam logic [SEL_W-1:0] SEL_B = 2'd1;
  localparam logic [SEL_W-1:0] SEL_C = 2'd2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 2'd1;
  localparam logic [MSIZE_W-1:0]   MATRIX_SIZE_RST = 5'd16;
  localparam logic [RCOUNT_W-1:0]  ROUND_COUNT_RST = 6'd10;

  // Cell operation for the current read
  typedef enum logic [1:0] {
    OP_NONE,
    OP_ACC_B,
    OP_ACC_C,
    OP_ACC_A
  } mpv_op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BC,
    ST_DRAIN1,
    ST_LOAD,
    ST_A,
    ST_DRAIN2,
    ST_DONE
  } mpv_state_e;

  // Control broadcast to every cell
  typedef struct packed {
    logic             clr;
    logic             load_ring;
    logic             rotate;
    mpv_op_e          op;
    logic [IDX_W-1:0] col;
    logic             xbit;
  } mpv_ctl_t;

  // Word passed around the ring: one entry of B*X with its column tag
  typedef struct packed {
    logic                    vld;
    logic signed [BX_W-1:0]  bx;
    logic [IDX_W-1:0]        col;
  } mpv_ring_t;

endpackage

[design/matrix_product_verifier.sv]
// Freivalds verifier top: command decode, sequencer and the row of cells.
// Round: the strobe follows a pass over B and C with one RAM read per cell per cycle, a
// drain, the ring load, a pass over A and a second drain; busy holds off the next word
// until the round ends. Load: one per cycle while idle, no result.
// Restart, or a round once the verdict stands: strobe on the next cycle.
// Reset: size 16, round count 10, status clear, matrices undefined; no result stall.
module matrix_product_verifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mpv_pkg::CMD_W-1:0]      command_i,
  input  logic [mpv_pkg::SEL_W-1:0]      matrix_select_i,
  input  logic [mpv_pkg::POS_W-1:0]      row_index_i,
  input  logic [mpv_pkg::POS_W-1:0]      col_index_i,
  input  logic signed [mpv_pkg::VALUE_W-1:0] element_value_i,
  input  logic [mpv_pkg::RAND_W-1:0]     random_bits_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mpv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mpv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output logic                           round_match_o,
  output logic                           verdict_valid_o,
  output logic                           product_equal_o,
  output logic [mpv_pkg::RCOUNT_W-1:0]   rounds_done_o
);
  import mpv_pkg::*;

  logic [MSIZE_W-1:0]  matrix_size_q;
  logic [RCOUNT_W-1:0] round_count_q;
  logic [SIZE_W-1:0]   n_eff;
  mpv_state_e          state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [RAND_W-1:0]   random_q, rand_sh;
  logic [RCOUNT_W-1:0] passed_q, passed_d;
  logic                failed_q, failed_d;
  logic                accept, done_now, all_match;
  logic                wr_en;
  logic [RAM_AW-1:0]   wr_addr;
  logic [ELEM_W-1:0]   wr_data;
  mpv_ctl_t            ctl;
  logic                emit, emit_match;
  logic [RCOUNT_W-1:0] st_passed;
  logic                st_failed;
  logic                res_valid_q, round_match_q, verdict_q, equal_q;
  logic [RCOUNT_W-1:0] rounds_q;
  logic [MAX_SIZE-1:0] cell_match, cell_we, cell_active;
  mpv_ring_t           ring_out [MAX_SIZE];

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= MATRIX_SIZE_RST;
      round_count_q <= ROUND_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MATRIX_SIZE: matrix_size_q <= MSIZE_W'(cfg_data_i);
        CFG_ROUND_COUNT: round_count_q <= RCOUNT_W'(cfg_data_i);
        default:         ;
      endcase
    end
  end

  // Clamp the size in use to the array
  assign n_eff = (32'(matrix_size_q) > MAX_SIZE) ? SIZE_W'(MAX_SIZE)
                                                 : SIZE_W'(matrix_size_q);

  assign done_now = failed_q || (passed_q >= round_count_q);

  // Element write: drop out-of-range positions and the unused select
  assign wr_en   = accept && (command_i == CMD_LOAD) && (matrix_select_i <= SEL_C)
                   && (32'(row_index_i) < MAX_SIZE) && (32'(col_index_i) < MAX_SIZE);
  assign wr_addr = {matrix_select_i, IDX_W'(col_index_i)};
  assign wr_data = ELEM_W'(element_value_i);

  // Hold the random vector for the round
  always_ff @(posedge clk_i) begin
    if (accept && (command_i == CMD_ROUND)) begin
      random_q <= random_bits_i;
    end
  end

  assign all_match = &cell_match;

  // Sequencer: next state, cell control and result selection
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    passed_d   = passed_q;
    failed_d   = failed_q;
    ctl        = '{clr: 1'b0, load_ring: 1'b0, rotate: 1'b0, op: OP_NONE,
                   col: '0, xbit: 1'b0};
    rand_sh    = '0;
    emit       = 1'b0;
    emit_match = 1'b0;
    st_passed  = passed_q;
    st_failed  = failed_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_ROUND: begin
              if (done_now) begin
                emit = 1'b1;
              end else begin
                ctl.clr = 1'b1;
                step_d  = '0;
                state_d = (n_eff == '0) ? ST_DRAIN1 : ST_BC;
              end
            end
            CMD_RESTART: begin
              passed_d  = '0;
              failed_d  = 1'b0;
              st_passed = '0;
              st_failed = 1'b0;
              emit      = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_BC: begin
        if (32'(step_q) < 32'(n_eff)) begin
          ctl.op  = OP_ACC_B;
          ctl.col = IDX_W'(step_q);
        end else begin
          ctl.op  = OP_ACC_C;
          ctl.col = IDX_W'(step_q - STEP_W'(n_eff));
        end
        rand_sh  = random_q >> ctl.col;
        ctl.xbit = rand_sh[0];
        if (step_q == STEP_W'(2 * n_eff - 1)) begin
          step_d  = '0;
          state_d = ST_DRAIN1;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN1: begin
        if (step_q == STEP_W'(PIPE_LAT - 1)) begin
          step_d  = '0;
          state_d = ST_LOAD;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_LOAD: begin
        ctl.load_ring = 1'b1;
        step_d        = '0;
        state_d       = ST_A;
      end
      ST_A: begin
        ctl.op     = OP_ACC_A;
        ctl.rotate = 1'b1;
        if (step_q == STEP_W'(MAX_SIZE - 1)) begin
          step_d  = '0;
          state_d = ST_DRAIN2;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN2: begin
        if (step_q == STEP_W'(PIPE_LAT - 1)) begin
          step_d  = '0;
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (all_match) begin
          passed_d = passed_q + 1'b1;
        end else begin
          failed_d = 1'b1;
        end
        st_passed  = passed_d;
        st_failed  = failed_d;
        emit       = 1'b1;
        emit_match = all_match;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, step counter and round status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      passed_q <= '0;
      failed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      passed_q <= passed_d;
      failed_q <= failed_d;
    end
  end

  // Result word, shown for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      round_match_q <= emit_match;
      verdict_q     <= st_failed || (st_passed >= round_count_q);
      equal_q       <= !st_failed && (st_passed >= round_count_q);
      rounds_q      <= st_passed;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign round_match_o   = round_match_q;
  assign verdict_valid_o = verdict_q;
  assign product_equal_o = equal_q;
  assign rounds_done_o   = rounds_q;

  // Row of cells; the ring closes from cell 0 back to the last cell
  for (genvar g = 0; g < MAX_SIZE; g++) begin : g_cell
    assign cell_we[g]     = wr_en && (IDX_W'(row_index_i) == IDX_W'(g));
    assign cell_active[g] = (SIZE_W'(g) < n_eff);

    mpv_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .active_i (cell_active[g]),
      .row_id_i (IDX_W'(g)),
      .wr_en_i  (cell_we[g]),
      .wr_addr_i(wr_addr),
      .wr_data_i(wr_data),
      .ring_i   (ring_out[(g + 1) % MAX_SIZE]),
      .ring_o   (ring_out[g]),
      .match_o  (cell_match[g])
    );
  end

  // A verdict of equal is never reported without a valid verdict
  a_equal_needs_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && product_equal_o |-> verdict_valid_o)
    else $error("product_equal without verdict_valid");

  // A load never produces a result word
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == CMD_LOAD) |=> !result_valid_o)
    else $error("result after a load");

  // The end of a round always delivers its result
  a_round_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> result_valid_o)
    else $error("round finished without a result");

  // Restart reports a cleared status
  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == CMD_RESTART)
    |=> result_valid_o && !round_match_o && (rounds_done_o == '0))
    else $error("restart result not cleared");

  // A passed round reports one more passed round than before
  a_pass_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && round_match_o |-> rounds_done_o == RCOUNT_W'($past(passed_q) + 1'b1))
    else $error("passed round count did not advance");

endmodule

[design/mpv_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module mpv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write and read; read data is registered and lands in the cycle after the address
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/mpv_cell.sv]
// One row cell: holds row r of A, B and C in a RAM, accumulates (B*X)[r],
// (C*X)[r] and (A*B*X)[r]. Uses mpv_pkg and mpv_ram.
module mpv_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpv_pkg::mpv_ctl_t          ctl_i,
  input  logic                       active_i,
  input  logic [mpv_pkg::IDX_W-1:0]  row_id_i,
  input  logic                       wr_en_i,
  input  logic [mpv_pkg::RAM_AW-1:0] wr_addr_i,
  input  logic [mpv_pkg::ELEM_W-1:0] wr_data_i,
  input  mpv_pkg::mpv_ring_t         ring_i,
  output mpv_pkg::mpv_ring_t         ring_o,
  output logic                       match_o
);
  import mpv_pkg::*;

  logic [RAM_AW-1:0]        rd_addr;
  logic [ELEM_W-1:0]        rd_data;
  logic                     use_s0;
  mpv_op_e                  op_s1_q, op_s2_q;
  logic                     use_s1_q;
  logic signed [BX_W-1:0]   bx_s1_q;
  logic signed [ELEM_W-1:0] elem_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  addend_d, addend_q;
  logic signed [BX_W-1:0]   bx_q;
  logic signed [ACC_W-1:0]  cx_q, abx_q;
  mpv_ring_t                ring_q;

  mpv_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en_i),
    .wr_addr_i(wr_addr_i),
    .wr_data_i(wr_data_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Pick the element to read: broadcast column for B and C, ring tag for A
  always_comb begin
    unique case (ctl_i.op)
      OP_ACC_B: rd_addr = {SEL_B, ctl_i.col};
      OP_ACC_C: rd_addr = {SEL_C, ctl_i.col};
      OP_ACC_A: rd_addr = {SEL_A, ring_q.col};
      default:  rd_addr = {SEL_A, ctl_i.col};
    endcase
    use_s0 = (ctl_i.op == OP_ACC_A) ? ring_q.vld : ctl_i.xbit;
  end

  // Track the operation alongside the RAM read and the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_s1_q <= OP_NONE;
      op_s2_q <= OP_NONE;
    end else begin
      op_s1_q <= ctl_i.op;
      op_s2_q <= op_s1_q;
    end
  end

  // Align the ring word with the element it multiplies
  always_ff @(posedge clk_i) begin
    use_s1_q <= use_s0;
    bx_s1_q  <= ring_q.bx;
  end

  // Form the term: element times B*X entry for A, the element itself for B and C
  assign elem_s = signed'(rd_data);
  assign prod   = elem_s * bx_s1_q;

  always_comb begin
    case (op_s1_q) inside
      OP_ACC_A:           addend_d = use_s1_q ? ACC_W'(prod) : '0;
      OP_ACC_B, OP_ACC_C: addend_d = use_s1_q ? ACC_W'(elem_s) : '0;
      default:            addend_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    addend_q <= addend_d;
  end

  // Accumulate into the sum that the operation names; clear at round start
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      bx_q  <= '0;
      cx_q  <= '0;
      abx_q <= '0;
    end else begin
      case (op_s2_q)
        OP_ACC_B: bx_q  <= bx_q + BX_W'(addend_q);
        OP_ACC_C: cx_q  <= cx_q + addend_q;
        OP_ACC_A: abx_q <= abx_q + addend_q;
        default:  ;
      endcase
    end
  end

  // Load own B*X entry into the ring, then pass words down the chain
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_ring) begin
      ring_q <= '{vld: active_i, bx: bx_q, col: row_id_i};
    end else if (ctl_i.rotate) begin
      ring_q <= ring_i;
    end
  end

  assign ring_o  = ring_q;
  assign match_o = !active_i || (abx_q == cx_q);

endmodule

[test/mpv_checker.sv]
// Checker for the matrix product verifier: watches the command, register and
// result channels, predicts each status word and compares it field by field.
// Depends on mpv_pkg for widths, command codes, selects and register indexes.
module mpv_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [mpv_pkg::CMD_W-1:0]           command_i,
  input  logic [mpv_pkg::SEL_W-1:0]           matrix_select_i,
  input  logic [mpv_pkg::POS_W-1:0]           row_index_i,
  input  logic [mpv_pkg::POS_W-1:0]           col_index_i,
  input  logic signed [mpv_pkg::VALUE_W-1:0]  element_value_i,
  input  logic [mpv_pkg::RAND_W-1:0]          random_bits_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [mpv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mpv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                result_valid_i,
  input  logic                                round_match_i,
  input  logic                                verdict_valid_i,
  input  logic                                product_equal_i,
  input  logic [mpv_pkg::RCOUNT_W-1:0]        rounds_done_i,
  output int                                  pending_o,
  output int                                  error_count_o
);
  import mpv_pkg::*;

  // One status word as the block reports it
  typedef struct packed {
    logic                round_match;
    logic                verdict_valid;
    logic                product_equal;
    logic [RCOUNT_W-1:0] rounds_done;
  } status_word_t;

  logic signed [ELEM_W-1:0] matrix_cells [3][MAX_SIZE][MAX_SIZE];
  logic [MSIZE_W-1:0]       size_in_use;
  logic [RCOUNT_W-1:0]      rounds_needed;
  logic [RCOUNT_W-1:0]      passed_rounds;
  logic                     product_failed;
  status_word_t             status_q [$];
  int                       failures = 0;

  assign error_count_o = failures;

  task automatic report_failure(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic logic verdict_reached();
    return product_failed || (passed_rounds >= rounds_needed);
  endfunction

  function automatic status_word_t current_status(input logic match);
    status_word_t word;
    word.round_match   = match;
    word.verdict_valid = verdict_reached();
    word.product_equal = verdict_reached() && !product_failed;
    word.rounds_done   = passed_rounds;
    return word;
  endfunction

  // Compare A*(B*X) with C*X over the rows and columns in use
  function automatic logic products_agree(input logic [RAND_W-1:0] xbits);
    longint     bx [MAX_SIZE];
    longint     abx;
    longint     cx;
    logic [63:0] diff;
    int         n;
    logic       agree;
    n = (size_in_use > MAX_SIZE) ? MAX_SIZE : int'(size_in_use);
    agree = 1'b1;
    for (int r = 0; r < n; r++) begin
      bx[r] = 0;
      for (int c = 0; c < n; c++) begin
        if (xbits[c]) bx[r] += longint'(matrix_cells[SEL_B][r][c]);
      end
    end
    for (int r = 0; r < n; r++) begin
      abx = 0;
      cx  = 0;
      for (int c = 0; c < n; c++) begin
        abx += longint'(matrix_cells[SEL_A][r][c]) * bx[c];
        if (xbits[c]) cx += longint'(matrix_cells[SEL_C][r][c]);
      end
      diff = abx ^ cx;
      if (diff[ACC_W-1:0] != '0) agree = 1'b0;
    end
    return agree;
  endfunction

  // Advance the predicted state by one accepted word
  task automatic apply_command();
    logic agree;
    case (command_i)
      CMD_LOAD: begin
        if (matrix_select_i <= SEL_C) begin
          matrix_cells[matrix_select_i][row_index_i][col_index_i] = element_value_i;
        end
      end
      CMD_ROUND: begin
        if (verdict_reached()) begin
          status_q.push_back(current_status(1'b0));
        end else begin
          agree = products_agree(random_bits_i);
          if (agree) passed_rounds = passed_rounds + 1'b1;
          else       product_failed = 1'b1;
          status_q.push_back(current_status(agree));
        end
      end
      CMD_RESTART: begin
        passed_rounds  = '0;
        product_failed = 1'b0;
        status_q.push_back(current_status(1'b0));
      end
      default: ;
    endcase
  endtask

  // Check results first: a result at this edge belongs to an older word
  always @(posedge clk_i or negedge rst_ni) begin
    status_word_t want;
    if (!rst_ni) begin
      size_in_use    = MATRIX_SIZE_RST;
      rounds_needed  = ROUND_COUNT_RST;
      passed_rounds  = '0;
      product_failed = 1'b0;
      status_q.delete();
      pending_o      = 0;
    end else begin
      if (result_valid_i) begin
        if (status_q.size() == 0) begin
          report_failure("result with no command waiting for one");
        end else begin
          want = status_q.pop_front();
          check_field("round_match", round_match_i, want.round_match);
          check_field("verdict_valid", verdict_valid_i, want.verdict_valid);
          check_field("product_equal", product_equal_i, want.product_equal);
          check_field("rounds_done", rounds_done_i, want.rounds_done);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MATRIX_SIZE: size_in_use   = cfg_data_i[MSIZE_W-1:0];
          CFG_ROUND_COUNT: rounds_needed = cfg_data_i[RCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) apply_command();
      pending_o = status_q.size();
    end
  end

endmodule

[test/tb_matrix_product_verifier.sv]
// Testbench top for the matrix product verifier: clock, reset, stimulus and
// the final verdict. Depends on mpv_pkg, the block and mpv_checker.
module tb_matrix_product_verifier;
  import mpv_pkg::*;

  localparam int                ITEM_TARGET  = 1750;
  localparam int                DRAIN_CYCLES = 64;
  localparam logic [CMD_W-1:0]  CMD_UNKNOWN  = 2'd3;
  localparam logic [SEL_W-1:0]  SEL_NONE     = 2'd3;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [CMD_W-1:0]           command;
  logic [SEL_W-1:0]           matrix_select;
  logic [POS_W-1:0]           row_index;
  logic [POS_W-1:0]           col_index;
  logic signed [VALUE_W-1:0]  element_value;
  logic [RAND_W-1:0]          random_bits;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       result_valid;
  logic                       round_match;
  logic                       verdict_valid;
  logic                       product_equal;
  logic [RCOUNT_W-1:0]        rounds_done;
  int                         pending;
  int                         failures;
  int                         items_sent;
  bit                         burst;

  matrix_product_verifier dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .command_i       (command),
    .matrix_select_i (matrix_select),
    .row_index_i     (row_index),
    .col_index_i     (col_index),
    .element_value_i (element_value),
    .random_bits_i   (random_bits),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .result_valid_o  (result_valid),
    .round_match_o   (round_match),
    .verdict_valid_o (verdict_valid),
    .product_equal_o (product_equal),
    .rounds_done_o   (rounds_done)
  );

  mpv_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .command_i       (command),
    .matrix_select_i (matrix_select),
    .row_index_i     (row_index),
    .col_index_i     (col_index),
    .element_value_i (element_value),
    .random_bits_i   (random_bits),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .result_valid_i  (result_valid),
    .round_match_i   (round_match),
    .verdict_valid_i (verdict_valid),
    .product_equal_i (product_equal),
    .rounds_done_i   (rounds_done),
    .pending_o       (pending),
    .error_count_o   (failures)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RAND_W-1:0] pick_vector();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return RAND_W'($urandom);
  endfunction

  // Present one word and hold it until accepted; called at a falling edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                           input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
                           input logic [VALUE_W-1:0] value,
                           input logic [RAND_W-1:0] xbits);
    int gap;
    start         = 1'b1;
    command       = cmd;
    matrix_select = sel;
    row_index     = row;
    col_index     = col;
    element_value = value;
    random_bits   = xbits;
    do @(posedge clk); while (busy);
    if ((cmd == CMD_LOAD && sel <= SEL_C) || cmd == CMD_ROUND || cmd == CMD_RESTART) begin
      items_sent++;
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_load(input logic [SEL_W-1:0] sel, input int row, input int col,
                           input logic [VALUE_W-1:0] value);
    send_item(CMD_LOAD, sel, POS_W'(row), POS_W'(col), value, RAND_W'($urandom));
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [RAND_W-1:0] xbits);
    send_item(cmd, SEL_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              VALUE_W'($urandom), xbits);
  endtask

  // Words the block must ignore
  task automatic send_noise();
    if ($urandom_range(0, 1)) send_command(CMD_UNKNOWN, RAND_W'($urandom));
    else send_load(SEL_NONE, $urandom_range(0, 15), $urandom_range(0, 15), VALUE_W'($urandom));
  endtask

  // Hold off until every expected result is in and the block is idle
  task automatic wait_drained();
    start = 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Load A, B and C (mostly C = A*B), then run sets of check rounds
  task automatic verify_random_product(input bit oversize);
    int         mats [3][MAX_SIZE][MAX_SIZE];
    int         size, n, rc, roll, rounds, pr, pc, delta;
    bit         wide, perturbed;
    size = 0;
    roll = $urandom_range(0, 59);
    if (oversize || roll == 0) size = $urandom_range(17, 31);
    else if (roll == 1)        size = 0;
    else if (roll == 2)        size = 16;
    else if (roll <= 5)        size = $urandom_range(7, 15);
    else                       size = $urandom_range(1, 6);
    n = (size > MAX_SIZE) ? MAX_SIZE : size;
    roll = $urandom_range(0, 15);
    if (roll == 0)      rc = 0;
    else if (roll == 1) rc = 63;
    else                rc = $urandom_range(1, 8);
    wide  = ($urandom_range(0, 5) == 0);
    burst = ($urandom_range(0, 3) == 0);

    write_reg(CFG_MATRIX_SIZE, {1'($urandom), MSIZE_W'(size)});
    write_reg(CFG_ROUND_COUNT, CFG_DATA_W'(rc));

    // Small factors keep every entry of A*B inside the element range
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        mats[SEL_A][r][c] = wide ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 80) - 40;
        mats[SEL_B][r][c] = wide ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 80) - 40;
      end
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        mats[SEL_C][r][c] = 0;
        for (int k = 0; k < n; k++) mats[SEL_C][r][c] += mats[SEL_A][r][k] * mats[SEL_B][k][c];
        if (wide) mats[SEL_C][r][c] = $urandom_range(0, 65535) - 32768;
      end
    end

    for (int m = SEL_A; m <= SEL_C; m++) begin
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) begin
          if ($urandom_range(0, 19) == 0) send_noise();
          send_load(SEL_W'(m), r, c, VALUE_W'(mats[m][r][c]));
        end
      end
    end
    // Stray writes outside the region in use
    if (n < MAX_SIZE) begin
      repeat (2) begin
        send_load(SEL_W'($urandom_range(SEL_A, SEL_C)), $urandom_range(n, 15),
                  $urandom_range(0, 15), VALUE_W'($urandom));
      end
    end

    perturbed = 1'b0;
    pr = 0;
    pc = 0;
    delta = 0;
    if (n > 0) begin
      pr = $urandom_range(0, n - 1);
      pc = $urandom_range(0, n - 1);
      delta = $urandom_range(1, 5);
    end
    repeat ($urandom_range(1, 2)) begin
      // Flip one entry of C between its product value and a near miss
      if (n > 0 && !wide && (perturbed || $urandom_range(0, 2) == 0)) begin
        perturbed = !perturbed;
        send_load(SEL_C, pr, pc,
                  VALUE_W'(mats[SEL_C][pr][pc] + (perturbed ? delta : 0)));
      end
      send_command(CMD_RESTART, RAND_W'($urandom));
      rounds = rc + $urandom_range(0, 3);
      repeat (rounds) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)      send_command(CMD_RESTART, RAND_W'($urandom));
        else if (roll < 7) send_noise();
        else if (roll < 9) wait_drained();
        send_command(CMD_ROUND, pick_vector());
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    command       = CMD_LOAD;
    matrix_select = SEL_A;
    row_index     = '0;
    col_index     = '0;
    element_value = '0;
    random_bits   = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_MATRIX_SIZE;
    cfg_data      = '0;
    items_sent    = 0;
    burst         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one by one product with the extreme element values
    write_reg(CFG_MATRIX_SIZE, CFG_DATA_W'(1));
    write_reg(CFG_ROUND_COUNT, CFG_DATA_W'(2));
    send_load(SEL_A, 0, 0, 16'sh8000);
    send_load(SEL_B, 0, 0, 16'sh7FFF);
    send_load(SEL_C, 0, 0, '0);
    send_load(SEL_NONE, 15, 15, '1);
    send_command(CMD_UNKNOWN, '1);
    // X entry 0 clear: both sides are zero
    send_command(CMD_ROUND, 16'hFFFE);
    send_command(CMD_ROUND, 16'hFFFF);
    // Round once the verdict stands
    send_command(CMD_ROUND, 16'hFFFF);
    send_command(CMD_RESTART, '0);
    send_load(SEL_A, 0, 0, 16'sh0001);
    send_load(SEL_B, 0, 0, '1);
    send_load(SEL_C, 0, 0, '1);
    repeat (3) send_command(CMD_ROUND, 16'h0001);
    send_command(CMD_RESTART, '0);
    // Round count zero: verdict holds before any round
    write_reg(CFG_ROUND_COUNT, '0);
    send_command(CMD_ROUND, 16'h0001);
    // Empty product: every round matches
    write_reg(CFG_MATRIX_SIZE, '0);
    write_reg(CFG_ROUND_COUNT, CFG_DATA_W'(63));
    send_command(CMD_ROUND, '1);
    send_command(CMD_ROUND, '0);
    send_command(CMD_RESTART, '0);

    // Random: one oversize product, then mostly small ones
    verify_random_product(1'b1);
    while (items_sent < ITEM_TARGET) verify_random_product(1'b0);

    start = 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
